// ----- rtl/soft_edge_luma_key_blend_unit_defines.svh -----
// ----------------------------------------------------------------------------
// soft_edge_luma_key_blend_unit_defines.svh
// Assertion macros used by the luma key blend top module.
// ----------------------------------------------------------------------------
`ifndef SOFT_EDGE_LUMA_KEY_BLEND_UNIT_DEFINES_SVH
`define SOFT_EDGE_LUMA_KEY_BLEND_UNIT_DEFINES_SVH

// Implication checked at every edge outside reset; clk and rst_n come from
// the module that uses the macro.
`define SLKB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define SLKB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/slkb_pkg.sv -----
// ----------------------------------------------------------------------------
// slkb_pkg
// Types, constants and the rounded divide by 255 for the luma key blend.
// ----------------------------------------------------------------------------
`default_nettype none

package slkb_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_OPACITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_HIGH = 2'd2;

  localparam logic [PIX_W-1:0] OPACITY_RST   = 8'd150;
  localparam logic [PIX_W-1:0] LUMA_LOW_RST  = 8'd40;
  localparam logic [PIX_W-1:0] LUMA_HIGH_RST = 8'd176;

  localparam logic [PIX_W-1:0] KEY_FULL   = 8'd255;
  localparam logic [2:0]       RAMP_SPAN  = 3'd4;
  localparam logic [16:0]      ROUND_HALF = 17'd128;

  typedef struct packed {
    logic [PIX_W-1:0] base_luma;
    logic [PIX_W-1:0] base_cb;
    logic [PIX_W-1:0] base_cr;
    logic [PIX_W-1:0] overlay_luma;
    logic [PIX_W-1:0] overlay_cb;
    logic [PIX_W-1:0] overlay_cr;
    logic             last_in;
  } slkb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] mixed_luma;
    logic [PIX_W-1:0] mixed_cb;
    logic [PIX_W-1:0] mixed_cr;
    logic             last_out;
  } slkb_out_t;

  // beat after the key stage
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] mask;
    slkb_in_t         pix;
  } slkb_key_t;

  // beat after the weight stages
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] w;
    slkb_in_t         pix;
  } slkb_wgt_t;

  // v / 255 rounded, valid for v up to 255 * 255
  function automatic logic [PIX_W-1:0] rdiv255(input logic [PROD_W-1:0] v);
    logic [16:0] t;
    logic [17:0] s;
    t = {1'b0, v} + ROUND_HALF;
    s = {1'b0, t} + {9'b0, t[16:8]};
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/slkb_key.sv -----
// ----------------------------------------------------------------------------
// slkb_key
// Key stage: orders the thresholds and turns base luma into a soft mask.
// ----------------------------------------------------------------------------
`default_nettype none

module slkb_key (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    acc_i,
  input  wire slkb_pkg::slkb_in_t      pix_i,
  input  wire logic [7:0]              lo_thr_i,
  input  wire logic [7:0]              hi_thr_i,
  output slkb_pkg::slkb_key_t          key_o
);
  import slkb_pkg::*;

  logic [PIX_W-1:0] lo, hi, y;
  logic [PIX_W:0]   d_lo, d_hi;
  logic [2:0]       ramp;
  logic [PIX_W-1:0] mask_nxt;

  logic             valid_r;
  logic [PIX_W-1:0] mask_r;
  slkb_in_t         pix_r;

  always_comb begin
    lo   = (hi_thr_i < lo_thr_i) ? hi_thr_i : lo_thr_i;
    hi   = (hi_thr_i < lo_thr_i) ? lo_thr_i : hi_thr_i;
    y    = pix_i.base_luma;
    d_lo = {1'b0, lo} - {1'b0, y};
    d_hi = {1'b0, y} - {1'b0, hi};
    ramp = '0;
    if (y >= lo && y <= hi) begin
      mask_nxt = KEY_FULL;
    end else if (y < lo && d_lo < {6'd0, RAMP_SPAN}) begin
      ramp     = RAMP_SPAN - d_lo[2:0];
      mask_nxt = {ramp[1:0], 6'd0};
    end else if (y > hi && d_hi < {6'd0, RAMP_SPAN}) begin
      ramp     = RAMP_SPAN - d_hi[2:0];
      mask_nxt = {ramp[1:0], 6'd0};
    end else begin
      mask_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc_i;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    pix_r  <= pix_i;
  end

  assign key_o = '{valid: valid_r, mask: mask_r, pix: pix_r};

endmodule

`default_nettype wire

// ----- rtl/slkb_weight.sv -----
// ----------------------------------------------------------------------------
// slkb_weight
// Weight stages: mask times opacity, then the rounded divide by 255.
// ----------------------------------------------------------------------------
`default_nettype none

module slkb_weight (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire slkb_pkg::slkb_key_t     key_i,
  input  wire logic [7:0]              opacity_i,
  output slkb_pkg::slkb_wgt_t          wgt_o
);
  import slkb_pkg::*;

  logic              valid2_r, valid3_r;
  logic [PROD_W-1:0] prod_r;
  logic [PIX_W-1:0]  w_r;
  slkb_in_t          pix2_r, pix3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      valid2_r <= key_i.valid;
      valid3_r <= valid2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= key_i.mask * opacity_i;
    pix2_r <= key_i.pix;
    w_r    <= rdiv255(prod_r);
    pix3_r <= pix2_r;
  end

  assign wgt_o = '{valid: valid3_r, w: w_r, pix: pix3_r};

endmodule

`default_nettype wire

// ----- rtl/slkb_mix.sv -----
// ----------------------------------------------------------------------------
// slkb_mix
// One channel of the blend: two products, their sum, rounded divide by 255, or the base value when the weight is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module slkb_mix (
  input  wire logic       clk,
  input  wire logic [7:0] w_i,
  input  wire logic [7:0] base_i,
  input  wire logic [7:0] over_i,
  output logic      [7:0] mix_o
);
  import slkb_pkg::*;

  logic [PROD_W-1:0] pa_r, pb_r, sum_r;
  logic [PIX_W-1:0]  base4_r, base5_r, mix_r;
  logic              wz4_r, wz5_r;

  always_ff @(posedge clk) begin
    pa_r    <= (KEY_FULL - w_i) * base_i;
    pb_r    <= w_i * over_i;
    wz4_r   <= (w_i == '0);
    base4_r <= base_i;
    sum_r   <= pa_r + pb_r;
    wz5_r   <= wz4_r;
    base5_r <= base4_r;
    mix_r   <= wz5_r ? base5_r : rdiv255(sum_r);
  end

  assign mix_o = mix_r;

endmodule

`default_nettype wire

// ----- rtl/soft_edge_luma_key_blend_unit.sv -----
// ----------------------------------------------------------------------------
// soft_edge_luma_key_blend_unit
// Soft-edge luma key and alpha blend of two YUV 4:4:4 pixel streams.
//
//   channel  ports                           beat
//   input    start, busy, in_data            one base/overlay pixel pair
//   result   out_strobe, out_data            one blended pixel
//   config   cfg_we, cfg_index, cfg_wdata    one register write
//
// One pixel per clock; each result passes through the six-stage datapath
// (key, product, weight, channel products, sum, divide). busy stays low.
// Synchronous reset clears the stage valid bits and loads the register
// defaults. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "soft_edge_luma_key_blend_unit_defines.svh"

module soft_edge_luma_key_blend_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire slkb_pkg::slkb_in_t                 in_data,
  output logic                                    out_strobe,
  output slkb_pkg::slkb_out_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [slkb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [slkb_pkg::CFG_W-1:0]         cfg_wdata
);
  import slkb_pkg::*;

  logic             acc;
  logic [PIX_W-1:0] opacity_r, luma_low_r, luma_high_r;
  slkb_key_t        key_q;
  slkb_wgt_t        wgt_q;
  logic [2:0]       vld_r, lst_r;
  logic [PIX_W-1:0] mix_y, mix_u, mix_v;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r   <= OPACITY_RST;
      luma_low_r  <= LUMA_LOW_RST;
      luma_high_r <= LUMA_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPACITY:   opacity_r   <= cfg_wdata;
        REG_LUMA_LOW:  luma_low_r  <= cfg_wdata;
        REG_LUMA_HIGH: luma_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  slkb_key u_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_i    (acc),
    .pix_i    (in_data),
    .lo_thr_i (luma_low_r),
    .hi_thr_i (luma_high_r),
    .key_o    (key_q)
  );

  slkb_weight u_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_i     (key_q),
    .opacity_i (opacity_r),
    .wgt_o     (wgt_q)
  );

  slkb_mix u_mix_y (
    .clk    (clk),
    .w_i    (wgt_q.w),
    .base_i (wgt_q.pix.base_luma),
    .over_i (wgt_q.pix.overlay_luma),
    .mix_o  (mix_y)
  );

  slkb_mix u_mix_u (
    .clk    (clk),
    .w_i    (wgt_q.w),
    .base_i (wgt_q.pix.base_cb),
    .over_i (wgt_q.pix.overlay_cb),
    .mix_o  (mix_u)
  );

  slkb_mix u_mix_v (
    .clk    (clk),
    .w_i    (wgt_q.w),
    .base_i (wgt_q.pix.base_cr),
    .over_i (wgt_q.pix.overlay_cr),
    .mix_o  (mix_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], wgt_q.valid};
    end
  end

  always_ff @(posedge clk) begin
    lst_r <= {lst_r[1:0], wgt_q.pix.last_in};
  end

  assign out_strobe = vld_r[2];
  assign out_data   = '{mixed_luma: mix_y, mixed_cb: mix_u, mixed_cr: mix_v,
                        last_out: lst_r[2]};

  `SLKB_ASSERT(a_latency, (start && !busy) |-> ##6 out_strobe, "beat lost in pipeline")
  `SLKB_ASSERT(a_last, (start && !busy && in_data.last_in) |-> ##6 out_data.last_out, "last flag not carried")
  `SLKB_ASSERT(a_zero_mask, (key_q.valid && key_q.mask == '0) |-> ##2 (wgt_q.w == '0), "weight nonzero outside key")

endmodule

`default_nettype wire
